FILE: hdl/gtxb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtxb_pkg
// Shared widths, command codes and step result type for the tagged GF(2)
// xor basis.
// ----------------------------------------------------------------------------
package gtxb_pkg;

  // vector and tag widths
  localparam int VEC_BITS = 45;
  localparam int TAG_BITS = 8;

  // pivot index and basis row store
  localparam int IDX_W    = $clog2(VEC_BITS);
  localparam int ROW_W    = VEC_BITS + TAG_BITS;

  // stream payload widths, whole bytes
  localparam int DATA_W   = ((VEC_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 1;

  typedef logic [VEC_BITS-1:0] vec_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // command codes carried on in_tuser
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REDUCE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // outcome of one elimination step
  typedef struct packed {
    vec_t vec;
    tag_t tag;
    logic store;
    logic done;
  } step_res_t;

endpackage

FILE: hdl/gtxb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtxb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gtxb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/gtxb_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtxb_step
// Shared elimination unit: handles one pivot position per cycle, folding in
// the stored row or claiming the empty pivot for an insert.
// ----------------------------------------------------------------------------
module gtxb_step (
  input  gtxb_pkg::cmd_t      cmd,
  input  gtxb_pkg::idx_t      pivot,
  input  gtxb_pkg::vec_t      vec,
  input  gtxb_pkg::tag_t      tag,
  input  gtxb_pkg::vec_t      row_vec,
  input  gtxb_pkg::tag_t      row_tag,
  input  logic                row_valid,
  output gtxb_pkg::step_res_t res
);

  import gtxb_pkg::*;

  logic lead_bit;
  logic last_pivot;

  assign lead_bit   = vec[pivot];
  assign last_pivot = (pivot == '0);

  // eliminate against the row at this pivot, or store into an empty one
  always_comb begin
    res.vec   = vec;
    res.tag   = tag;
    res.store = 1'b0;
    res.done  = last_pivot;
    priority if (!lead_bit) begin
      res.done = last_pivot;
    end else if (row_valid) begin
      res.vec = vec ^ row_vec;
      res.tag = tag ^ row_tag;
    end else if (cmd == CMD_INSERT) begin
      res.store = 1'b1;
      res.done  = 1'b1;
    end else begin
      res.done = last_pivot;
    end
  end

endmodule

FILE: hdl/gf2_tagged_xor_basis_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_tagged_xor_basis_top
// Tagged GF(2) xor basis in row-echelon form with insert, reduce and clear.
// ----------------------------------------------------------------------------
// Each input beat is one command. Insert and reduce walk the pivots from the
// highest bit down, one pivot per cycle through a single xor unit fed by the
// basis row RAM: a priming state reads the top row, then the processing state
// handles each pivot in turn before the final state loads the result
// register; an insert that claims a pivot finishes early. Clear and unused
// commands go straight from acceptance to the final state. The input side is
// ready only when no command is in progress; the result register frees the
// engine as soon as it is loaded, and a result that is still waiting holds the
// engine in its final state. Reset and clear empty the basis at once through a
// per-row valid flag, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module gf2_tagged_xor_basis_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gtxb_pkg::DATA_W-1:0]         in_tdata,   // vector_in, tag_in
  input  logic [gtxb_pkg::IN_USER_W-1:0]      in_tuser,   // cmd
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gtxb_pkg::DATA_W-1:0]         out_tdata,  // residue, residual_tag
  output logic [gtxb_pkg::OUT_USER_W-1:0]     out_tuser   // added
);

  import gtxb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PRIME = 4'b0010,
    ST_PROC  = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [VEC_BITS-1:0] valid_r, valid_nxt;
  logic                out_valid_r, out_valid_nxt;

  cmd_t  cmd_r, cmd_nxt;
  idx_t  pivot_r, pivot_nxt;
  vec_t  vec_r, vec_nxt;
  tag_t  tag_r, tag_nxt;
  logic  added_r, added_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic            in_beat;
  logic            ram_we;
  idx_t            ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  step_res_t       step;
  vec_t            in_vec;
  tag_t            in_tag;
  cmd_t            in_cmd;

  assign in_vec  = in_tdata[VEC_BITS-1:0];
  assign in_tag  = in_tdata[VEC_BITS +: TAG_BITS];
  assign in_cmd  = cmd_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;

  // basis row store
  assign ram_we    = (state_r == ST_PROC) && step.store;
  assign ram_raddr = (state_r == ST_PRIME) ? IDX_W'(VEC_BITS - 1) :
                     ((pivot_r == '0) ? '0 : pivot_r - 1'b1);

  gtxb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(VEC_BITS)
  ) u_rows (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pivot_r),
    .wdata({tag_r, vec_r}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared elimination unit
  gtxb_step u_step (
    .cmd      (cmd_r),
    .pivot    (pivot_r),
    .vec      (vec_r),
    .tag      (tag_r),
    .row_vec  (ram_rdata[VEC_BITS-1:0]),
    .row_tag  (ram_rdata[VEC_BITS +: TAG_BITS]),
    .row_valid(valid_r[pivot_r]),
    .res      (step)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd_nxt       = cmd_r;
    pivot_nxt     = pivot_r;
    vec_nxt       = vec_r;
    tag_nxt       = tag_r;
    added_nxt     = added_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          cmd_nxt   = in_cmd;
          pivot_nxt = IDX_W'(VEC_BITS - 1);
          added_nxt = 1'b0;
          unique case (in_cmd)
            CMD_INSERT: begin
              vec_nxt   = in_vec;
              tag_nxt   = in_tag;
              state_nxt = ST_PRIME;
            end
            CMD_REDUCE: begin
              vec_nxt   = in_vec;
              tag_nxt   = '0;
              state_nxt = ST_PRIME;
            end
            CMD_CLEAR: begin
              valid_nxt = '0;
              vec_nxt   = '0;
              tag_nxt   = '0;
              state_nxt = ST_FIN;
            end
            default: begin
              vec_nxt   = '0;
              tag_nxt   = '0;
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_PRIME: begin
        state_nxt = ST_PROC;
      end
      ST_PROC: begin
        vec_nxt = step.vec;
        tag_nxt = step.tag;
        if (step.store) begin
          valid_nxt[pivot_r] = 1'b1;
          added_nxt          = 1'b1;
        end
        if (step.done) begin
          state_nxt = ST_FIN;
        end else begin
          pivot_nxt = pivot_r - 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = DATA_W'({tag_r, vec_r});
          out_user_nxt  = OUT_USER_W'(added_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pivot_r    <= pivot_nxt;
    vec_r      <= vec_nxt;
    tag_r      <= tag_nxt;
    added_r    <= added_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
